// ----- rtl/alll_pkg.sv -----
// Shared types, constants and helpers for the array linked list block.
// Used by alll_store and array_linked_list_with_free_list; no dependencies.
package alll_pkg;

  localparam int unsigned Slots    = 128;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned LinkW    = $clog2(Slots + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned SlotOutW = 7;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [LinkW-1:0] link_t;

  // Null link: one past the last slot index.
  localparam link_t Nil = LinkW'(Slots);

  localparam logic ActInsert = 1'b0;
  localparam logic ActDelete = 1'b1;

  typedef enum logic [1:0] {
    StDone      = 2'd0,
    StNotFound  = 2'd1,
    StDuplicate = 2'd2,
    StFull      = 2'd3
  } status_e;

  // One read and one write request to the slot store per cycle.
  typedef struct packed {
    logic            rd_en;
    slot_t           rd_addr;
    logic            key_we;
    logic            link_we;
    slot_t           wr_addr;
    link_t           wr_link;
    logic [KeyW-1:0] wr_key;
  } mem_req_t;

  // Any link at or beyond the slot count counts as null.
  function automatic link_t link_clip(link_t v);
    return (v >= Nil) ? Nil : v;
  endfunction

  function automatic slot_t to_slot(link_t v);
    return v[SlotW-1:0];
  endfunction

endpackage

// ----- rtl/array_linked_list_with_free_list.sv -----
// Top level of the array linked list with free-slot chain.
// Depends on alll_pkg and instantiates alll_store.
//
// The block keeps a singly linked list of unique 32-bit signed keys in 128
// slots, with the unused slots kept on a free chain. A command item is
// accepted at a rising edge where start is high and busy is low. Action zero
// inserts the key, action one deletes it. Busy stays high until the cycle in
// which the item's single result appears.
//
// Each item walks the list from its head, one slot per cycle, through the
// single read port of the slot store and one shared key comparator. Busy is
// high while the slots are visited, in the decision state and in the link
// updates of S_FREERD and S_LINKUP. The result comes in the first cycle
// with busy low, and the next item can be accepted at the edge that ends it.
//
// The result (status and slot) appears on status_o and slot_o for exactly one
// cycle, marked by out_valid_o; the receiver cannot stall it. After reset the
// list is empty and every slot sits on the free chain in ascending order.
module array_linked_list_with_free_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic signed [alll_pkg::KeyW-1:0] key_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [alll_pkg::SlotOutW-1:0] slot_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_FREERD = 5'b01000,
    S_LINKUP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic                      action_q, action_d;
  logic [alll_pkg::KeyW-1:0] key_q, key_d;
  alll_pkg::link_t           head_q, head_d;
  alll_pkg::link_t           free_q, free_d;
  alll_pkg::link_t           cur_q, cur_d;
  alll_pkg::link_t           prev_q, prev_d;
  alll_pkg::link_t           after_q, after_d;
  alll_pkg::link_t           steps_q, steps_d;
  logic                      hit_q, hit_d;

  logic                          out_valid_q, out_valid_d;
  alll_pkg::status_e             status_q, status_d;
  logic [alll_pkg::SlotOutW-1:0] slot_q, slot_d;

  alll_pkg::mem_req_t        req;
  logic [alll_pkg::KeyW-1:0] key_rd;
  alll_pkg::link_t           link_rd;
  alll_pkg::link_t           nxt;

  alll_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .key_rd_o  (key_rd),
    .link_rd_o (link_rd)
  );

  // The sequencer: it starts a read at the list head, then compares one
  // slot's key per cycle while the read of the following slot is issued.
  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    key_d       = key_q;
    head_d      = head_q;
    free_d      = free_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    after_d     = after_q;
    steps_d     = steps_q;
    hit_d       = hit_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    slot_d      = slot_q;
    req         = '0;
    nxt         = alll_pkg::link_clip(link_rd);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          action_d = action_i;
          key_d    = key_i;
          prev_d   = alll_pkg::Nil;
          steps_d  = '0;
          hit_d    = 1'b0;
          if (head_q != alll_pkg::Nil) begin
            req.rd_en   = 1'b1;
            req.rd_addr = alll_pkg::to_slot(head_q);
            cur_d       = head_q;
            state_d     = S_WALK;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end

      S_WALK: begin
        if (key_rd == key_q) begin
          hit_d   = 1'b1;
          after_d = nxt;
          state_d = S_DECIDE;
        end else begin
          prev_d  = cur_q;
          steps_d = steps_q + alll_pkg::LinkW'(1);
          // The walk also ends after visiting every slot once.
          if (nxt != alll_pkg::Nil &&
              steps_q != alll_pkg::LinkW'(alll_pkg::Slots - 1)) begin
            req.rd_en   = 1'b1;
            req.rd_addr = alll_pkg::to_slot(nxt);
            cur_d       = nxt;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (action_q == alll_pkg::ActInsert) begin
          if (hit_q) begin
            out_valid_d = 1'b1;
            status_d    = alll_pkg::StDuplicate;
            slot_d      = '0;
            state_d     = S_IDLE;
          end else if (free_q == alll_pkg::Nil) begin
            out_valid_d = 1'b1;
            status_d    = alll_pkg::StFull;
            slot_d      = '0;
            state_d     = S_IDLE;
          end else begin
            // Fetch the free head's link to advance the free chain.
            req.rd_en   = 1'b1;
            req.rd_addr = alll_pkg::to_slot(free_q);
            cur_d       = free_q;
            state_d     = S_FREERD;
          end
        end else begin
          if (!hit_q) begin
            out_valid_d = 1'b1;
            status_d    = alll_pkg::StNotFound;
            slot_d      = '0;
            state_d     = S_IDLE;
          end else begin
            // Push the found slot onto the free chain.
            req.link_we = 1'b1;
            req.wr_addr = alll_pkg::to_slot(cur_q);
            req.wr_link = free_q;
            free_d      = cur_q;
            if (prev_q == alll_pkg::Nil) begin
              head_d      = after_q;
              out_valid_d = 1'b1;
              status_d    = alll_pkg::StDone;
              slot_d      = alll_pkg::SlotOutW'(cur_q);
              state_d     = S_IDLE;
            end else begin
              state_d = S_LINKUP;
            end
          end
        end
      end

      S_FREERD: begin
        free_d      = nxt;
        req.key_we  = 1'b1;
        req.link_we = 1'b1;
        req.wr_addr = alll_pkg::to_slot(cur_q);
        req.wr_link = alll_pkg::Nil;
        req.wr_key  = key_q;
        if (prev_q == alll_pkg::Nil) begin
          head_d      = cur_q;
          out_valid_d = 1'b1;
          status_d    = alll_pkg::StDone;
          slot_d      = alll_pkg::SlotOutW'(cur_q);
          state_d     = S_IDLE;
        end else begin
          state_d = S_LINKUP;
        end
      end

      S_LINKUP: begin
        // Relink the predecessor: past the deleted slot, or to the new tail.
        req.link_we = 1'b1;
        req.wr_addr = alll_pkg::to_slot(prev_q);
        req.wr_link = (action_q == alll_pkg::ActDelete) ? after_q : cur_q;
        out_valid_d = 1'b1;
        status_d    = alll_pkg::StDone;
        slot_d      = alll_pkg::SlotOutW'(cur_q);
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= alll_pkg::Nil;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= alll_pkg::StDone;
      slot_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    key_q    <= key_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    after_q  <= after_d;
    steps_q  <= steps_d;
    hit_q    <= hit_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

endmodule

// ----- rtl/alll_store.sv -----
// Slot store: key memory and link memory with one shared read port.
// Depends on alll_pkg for widths and the request struct.
module alll_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alll_pkg::mem_req_t       req_i,
  output logic [alll_pkg::KeyW-1:0] key_rd_o,
  output alll_pkg::link_t          link_rd_o
);

  logic [alll_pkg::KeyW-1:0] key_mem  [alll_pkg::Slots];
  alll_pkg::link_t           link_mem [alll_pkg::Slots];
  logic [alll_pkg::Slots-1:0] link_valid_q;

  logic [alll_pkg::KeyW-1:0] key_rd_q;
  alll_pkg::link_t           link_raw_q;
  logic                      valid_rd_q;
  alll_pkg::slot_t           rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem[req_i.wr_addr] <= req_i.wr_key;
    end
    if (req_i.link_we) begin
      link_mem[req_i.wr_addr] <= req_i.wr_link;
    end
    if (req_i.rd_en) begin
      key_rd_q   <= key_mem[req_i.rd_addr];
      link_raw_q <= link_mem[req_i.rd_addr];
    end
  end

  // A link entry never written reads as its reset value, the next slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_valid_q <= '0;
      valid_rd_q   <= 1'b0;
      rd_addr_q    <= '0;
    end else begin
      if (req_i.link_we) begin
        link_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        valid_rd_q <= link_valid_q[req_i.rd_addr];
        rd_addr_q  <= req_i.rd_addr;
      end
    end
  end

  assign key_rd_o  = key_rd_q;
  assign link_rd_o = valid_rd_q ? link_raw_q
                                : alll_pkg::LinkW'(rd_addr_q) + alll_pkg::LinkW'(1);

endmodule
